/* src/itew_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// itew_pkg
// Shared types, word codes and sizes for the integer to English word block.
// ----------------------------------------------------------------------------
package itew_pkg;

    localparam int NUMBER_WIDTH = 31;
    localparam int WORD_WIDTH   = 5;
    localparam int DIGIT_COUNT  = 10;
    localparam int STEP_COUNT   = 16;
    localparam int STEP_WIDTH   = $clog2(STEP_COUNT);
    localparam int GROUP_COUNT  = 4;
    localparam int SLOTS_PER_GROUP = 5;
    localparam int SLOT_COUNT   = GROUP_COUNT * SLOTS_PER_GROUP;

    typedef logic [3:0] digit_t;
    typedef digit_t [DIGIT_COUNT-1:0] bcd_t;
    typedef logic [WORD_WIDTH-1:0] word_t;

    localparam word_t W_ZERO     = 5'd0;
    localparam word_t W_TEEN     = 5'd10;
    localparam word_t W_TENS     = 5'd18;
    localparam word_t W_HUNDRED  = 5'd28;
    localparam word_t W_THOUSAND = 5'd29;
    localparam word_t W_MILLION  = 5'd30;
    localparam word_t W_BILLION  = 5'd31;

    typedef enum logic [1:0] {
        FRONT_IDLE,
        FRONT_CONV,
        FRONT_DONE
    } front_state_t;

    function automatic word_t scale_word(input int g);
        word_t w;
        case (g)
            0:       w = W_BILLION;
            1:       w = W_MILLION;
            default: w = W_THOUSAND;
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

/* src/itew_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// itew_front
// Accepts a number and converts it to ten decimal digits, two bits a cycle.
// ----------------------------------------------------------------------------
module itew_front (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [itew_pkg::NUMBER_WIDTH-1:0]    number,
    output logic                                      push_valid,
    input  wire logic                                 push_ready,
    output itew_pkg::bcd_t                            push_data
);
    import itew_pkg::*;

    front_state_t          state_reg, state_next;
    logic [STEP_WIDTH-1:0] cnt_reg, cnt_next;
    logic [31:0]           shift_reg, shift_next;
    bcd_t                  bcd_reg, bcd_next;
    bcd_t                  bcd_step;
    logic                  accept;
    logic                  last_step;

    always_comb
    begin
        bcd_t        b;
        logic [31:0] s;
        b = bcd_reg;
        s = shift_reg;
        for (int k = 0; k < 2; k++)
        begin
            for (int i = 0; i < DIGIT_COUNT; i++)
            begin
                if (b[i] >= 4'd5)
                begin
                    b[i] = b[i] + 4'd3;
                end
            end
            b = bcd_t'({b, s[31]});
            s = {s[30:0], 1'b0};
        end
        bcd_step = b;
    end

    assign last_step = (cnt_reg == STEP_WIDTH'(STEP_COUNT - 1));
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        case (state_reg)
            FRONT_IDLE:
            begin
                in_ready   = 1'b1;
                push_valid = 1'b0;
                push_data  = bcd_step;
            end
            FRONT_CONV:
            begin
                in_ready   = last_step && push_ready;
                push_valid = last_step;
                push_data  = bcd_step;
            end
            FRONT_DONE:
            begin
                in_ready   = push_ready;
                push_valid = 1'b1;
                push_data  = bcd_reg;
            end
            default:
            begin
                in_ready   = 1'b0;
                push_valid = 1'b0;
                push_data  = bcd_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FRONT_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = FRONT_CONV;
                end
            end
            FRONT_CONV:
            begin
                if (last_step)
                begin
                    if (!push_ready)
                    begin
                        state_next = FRONT_DONE;
                    end
                    else if (in_valid)
                    begin
                        state_next = FRONT_CONV;
                    end
                    else
                    begin
                        state_next = FRONT_IDLE;
                    end
                end
            end
            FRONT_DONE:
            begin
                if (push_ready)
                begin
                    state_next = in_valid ? FRONT_CONV : FRONT_IDLE;
                end
            end
            default:
            begin
                state_next = FRONT_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        bcd_next   = bcd_reg;
        if (accept)
        begin
            cnt_next   = '0;
            shift_next = {1'b0, number};
            bcd_next   = '0;
        end
        else if (state_reg == FRONT_CONV)
        begin
            cnt_next   = cnt_reg + 1'b1;
            shift_next = {shift_reg[29:0], 2'b00};
            bcd_next   = bcd_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FRONT_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        bcd_reg   <= bcd_next;
    end

endmodule
`default_nettype wire

/* src/itew_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// itew_fifo
// Two-entry queue of digit sets between the converter and the word sequencer.
// ----------------------------------------------------------------------------
module itew_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push_valid,
    output logic                push_ready,
    input  wire itew_pkg::bcd_t push_data,
    output logic                pop_valid,
    input  wire logic           pop,
    output itew_pkg::bcd_t      pop_data
);
    import itew_pkg::*;

    bcd_t       mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

/* src/itew_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// itew_back
// Walks the word slots of one number, one word per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module itew_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            head_valid,
    input  wire itew_pkg::bcd_t  head_data,
    output logic                 pop,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output itew_pkg::word_t      word,
    output logic                 last
);
    import itew_pkg::*;

    logic [SLOT_COUNT-1:0] slot_valid;
    word_t                 slot_code [SLOT_COUNT];
    digit_t                grp [GROUP_COUNT][3];
    logic [SLOT_COUNT-1:0] done_mask_reg, done_mask_next;
    logic [SLOT_COUNT-1:0] remain;
    logic [SLOT_COUNT-1:0] sel;
    logic                  sel_last;
    word_t                 sel_code;
    logic                  emit;
    logic                  out_valid_reg, out_valid_next;
    word_t                 word_reg, word_next;
    logic                  last_reg, last_next;

    always_comb
    begin
        grp[0][0] = 4'd0;
        grp[0][1] = 4'd0;
        grp[0][2] = head_data[9];
        grp[1][0] = head_data[8];
        grp[1][1] = head_data[7];
        grp[1][2] = head_data[6];
        grp[2][0] = head_data[5];
        grp[2][1] = head_data[4];
        grp[2][2] = head_data[3];
        grp[3][0] = head_data[2];
        grp[3][1] = head_data[1];
        grp[3][2] = head_data[0];
    end

    always_comb
    begin
        for (int g = 0; g < GROUP_COUNT; g++)
        begin
            slot_valid[g*5]     = (grp[g][0] != 4'd0);
            slot_code[g*5]      = {1'b0, grp[g][0]};
            slot_valid[g*5 + 1] = (grp[g][0] != 4'd0);
            slot_code[g*5 + 1]  = W_HUNDRED;
            slot_valid[g*5 + 2] = (grp[g][1] != 4'd0) || (grp[g][2] != 4'd0);
            if (grp[g][1] >= 4'd2)
            begin
                slot_code[g*5 + 2] = W_TENS + {1'b0, grp[g][1]};
            end
            else if (grp[g][1] == 4'd1)
            begin
                slot_code[g*5 + 2] = W_TEEN + {1'b0, grp[g][2]};
            end
            else
            begin
                slot_code[g*5 + 2] = {1'b0, grp[g][2]};
            end
            slot_valid[g*5 + 3] = (grp[g][1] >= 4'd2) && (grp[g][2] != 4'd0);
            slot_code[g*5 + 3]  = {1'b0, grp[g][2]};
            slot_valid[g*5 + 4] = (g != GROUP_COUNT - 1) &&
                                  ((grp[g][0] != 4'd0) || (grp[g][1] != 4'd0) ||
                                   (grp[g][2] != 4'd0));
            slot_code[g*5 + 4]  = scale_word(g);
        end
        if (head_data == '0)
        begin
            slot_valid[0] = 1'b1;
            slot_code[0]  = W_ZERO;
        end
    end

    always_comb
    begin
        remain   = slot_valid & ~done_mask_reg;
        sel      = remain & (~remain + 1'b1);
        sel_last = ((remain & (remain - 1'b1)) == '0);
        sel_code = '0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            sel_code = sel_code | (slot_code[i] & {WORD_WIDTH{sel[i]}});
        end
    end

    assign emit = head_valid && (!out_valid_reg || out_ready);
    assign pop  = emit && sel_last;

    always_comb
    begin
        done_mask_next = done_mask_reg;
        out_valid_next = out_valid_reg && !out_ready;
        word_next      = word_reg;
        last_next      = last_reg;
        if (emit)
        begin
            done_mask_next = sel_last ? '0 : (done_mask_reg | sel);
            out_valid_next = 1'b1;
            word_next      = sel_code;
            last_next      = sel_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_mask_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            done_mask_reg <= done_mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        last_reg <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign word      = word_reg;
    assign last      = last_reg;

endmodule
`default_nettype wire

/* src/integer_to_english_word_tokens.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// integer_to_english_word_tokens
// Names a 31-bit non-negative integer as a sequence of English word codes.
//
// The input channel (in_valid, in_ready, number) takes one number. The
// output channel (out_valid, out_ready, word, last) gives its words in
// reading order, one word per cycle while out_ready is high, with last
// set on the final word. The front converter forms ten decimal digits,
// two bits per cycle, and takes no new number before its last step. The
// first word of a number passes the front converter, the queue and the
// output register; its other words follow while out_ready is high.
// A two-entry queue of digit sets lets the converter start the next number
// while the word sequencer is still emitting, and the output register
// passes one word per cycle while out_ready stays high. When the
// receiver stalls, the current word is held and the queue fills, after
// which in_ready stays low. Reset clears all control state and leaves the
// block empty and ready.
// ----------------------------------------------------------------------------
module integer_to_english_word_tokens (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [itew_pkg::NUMBER_WIDTH-1:0] number,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [itew_pkg::WORD_WIDTH-1:0]        word,
    output logic                                   last
);
    import itew_pkg::*;

    logic  push_valid;
    logic  push_ready;
    bcd_t  push_data;
    logic  head_valid;
    bcd_t  head_data;
    logic  pop;
    word_t word_int;

    itew_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .number     (number),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    itew_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (head_valid),
        .pop        (pop),
        .pop_data   (head_data)
    );

    itew_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .word       (word_int),
        .last       (last)
    );

    assign word = word_int;

endmodule
`default_nettype wire
